### hdl/canonical_kmer_sampler_defines.svh
// Assertion macros for the canonical k-mer sampler.
`ifndef CANONICAL_KMER_SAMPLER_DEFINES_SVH
`define CANONICAL_KMER_SAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define CKMS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CKMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define CKMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CKMS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define CKMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define CKMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/ckms_pkg.sv
package ckms_pkg;

    localparam int DEFAULT_MAX_K = 32;
    localparam int CODE_W        = 64;
    localparam int SHIFT_W       = 6;
    localparam int KLEN_W        = 6;
    localparam int STRIDE_W      = 8;
    localparam int CHAR_W        = 8;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int REG_IDX_W     = ADDR_W - 2;

    localparam logic [KLEN_W-1:0]   KMER_LEN_RESET = 6'd17;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 8'd10;

    localparam logic [REG_IDX_W-1:0] REG_KMER_LEN = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE   = 1'd1;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic [KLEN_W-1:0]   kmer_length;
        logic [STRIDE_W-1:0] sample_stride;
    } cfg_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] val;
    } base_dec_t;

    function automatic base_dec_t decode_base(input logic [CHAR_W-1:0] ch);
        base_dec_t d;
        d.ok = 1'b1;
        case (ch) inside
            "A", "a": d.val = BASE_A;
            "C", "c": d.val = BASE_C;
            "G", "g": d.val = BASE_G;
            "T", "t": d.val = BASE_T;
            default:
            begin
                d.ok  = 1'b0;
                d.val = BASE_A;
            end
        endcase
        return d;
    endfunction

endpackage

### hdl/ckms_cfg.sv
module ckms_cfg
    import ckms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_KMER_LEN: cfg_next.kmer_length   = pwdata[KLEN_W-1:0];
                REG_STRIDE:   cfg_next.sample_stride = pwdata[STRIDE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KMER_LEN: prdata = DATA_W'(cfg_reg.kmer_length);
            REG_STRIDE:   prdata = DATA_W'(cfg_reg.sample_stride);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kmer_length   <= KMER_LEN_RESET;
            cfg_reg.sample_stride <= STRIDE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/canonical_kmer_sampler.sv
// Canonical k-mer sampler. A base is held in the input stage register, and a sampled
// k-mer is registered in the output stage. Throughput: one base per cycle, set by the
// rolling code update, while the output is not stalled and no reduction is pending; a
// register write holds off base processing while phase and window target are reduced by the new stride.
// Reset (async, active low): clears rolling codes, counters and stride phase,
// empties both stages; registers return to k = 17 and stride = 10.
`include "canonical_kmer_sampler_defines.svh"

module canonical_kmer_sampler
    import ckms_pkg::*;
#(
    parameter int MAX_K = DEFAULT_MAX_K
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                base_valid,
    output logic                base_ready,
    input  logic [CHAR_W-1:0]   base_char,
    input  logic                read_end,
    output logic                kmer_valid,
    input  logic                kmer_ready,
    output logic [CODE_W-1:0]   kmer_code
);

    localparam int CW    = $clog2(MAX_K + 1);
    localparam int DVC_W = $clog2(STRIDE_W + 2);
    localparam int K_RST = (int'(KMER_LEN_RESET) == 0) ? 1 :
                           ((int'(KMER_LEN_RESET) > MAX_K) ? MAX_K : int'(KMER_LEN_RESET));
    localparam int S_RST = (int'(STRIDE_RESET) == 0) ? 1 : int'(STRIDE_RESET);
    localparam logic [STRIDE_W-1:0] TGT_RST = STRIDE_W'((K_RST - 1) % S_RST);
    localparam logic [DVC_W-1:0]    DV_LOAD = DVC_W'(STRIDE_W + 1);

    cfg_t cfg;

    ckms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;
    logic              s1_adv;
    logic              s1_fire;

    // rolling state
    logic [CODE_W-1:0]   fwd_reg, fwd_next;
    logic [CODE_W-1:0]   rev_reg, rev_next;
    logic [CW-1:0]       vr_reg, vr_next;
    logic [CW-1:0]       bs_reg, bs_next;
    logic [STRIDE_W-1:0] phase_reg, phase_next;
    logic [STRIDE_W-1:0] tgt_reg, tgt_next;

    // output stage
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg;

    // phase and target reduction after a register write, one bit per cycle
    logic                cfg_wr;
    logic                dv_busy;
    logic [DVC_W-1:0]    dv_cnt_reg, dv_cnt_next;
    logic [STRIDE_W-1:0] dv_pnum_reg, dv_pnum_next;
    logic [STRIDE_W-1:0] dv_prem_reg, dv_prem_next;
    logic [STRIDE_W-1:0] dv_tnum_reg, dv_tnum_next;
    logic [STRIDE_W-1:0] dv_trem_reg, dv_trem_next;
    logic [STRIDE_W:0]   dv_psh, dv_tsh;
    logic [STRIDE_W:0]   dv_pdiff, dv_tdiff;
    logic [STRIDE_W-1:0] dv_pstep, dv_tstep;

    logic [CW-1:0]       k_eff;
    logic [STRIDE_W-1:0] s_eff;
    logic [CODE_W-1:0]   kmask;
    logic [SHIFT_W-1:0]  rev_sh;
    base_dec_t           bd;
    logic [CODE_W-1:0]   fwd_new, rev_new;
    logic [CW:0]         vr_inc, bs_inc;
    logic [CW-1:0]       vr_new, bs_new;
    logic [STRIDE_W:0]   phase_inc;
    logic                hit;
    logic [CODE_W-1:0]   canon;
    logic                last_fire;
    logic                st_clear;

    assign cfg_wr     = psel && penable && pwrite && pready;
    assign dv_busy    = (dv_cnt_reg != '0);
    assign s1_adv     = (!out_valid_reg || kmer_ready) && !dv_busy;
    assign s1_fire    = s1_valid_reg && s1_adv;
    assign base_ready = !s1_valid_reg || s1_fire;
    assign kmer_valid = out_valid_reg;
    assign kmer_code  = out_code_reg;

    always_comb
    begin
        if (cfg.kmer_length == '0)
            k_eff = CW'(1);
        else if (int'(cfg.kmer_length) > MAX_K)
            k_eff = CW'(MAX_K);
        else
            k_eff = CW'(cfg.kmer_length);
        s_eff = (cfg.sample_stride == '0) ? STRIDE_W'(1) : cfg.sample_stride;
        for (int i = 0; i < CODE_W; i++)
        begin
            kmask[i] = (i < 2 * int'(k_eff));
        end
        rev_sh = SHIFT_W'({k_eff - CW'(1), 1'b0});
    end

    always_comb
    begin
        bd      = decode_base(s1_char_reg);
        fwd_new = ({fwd_reg[CODE_W-3:0], 2'b00} | CODE_W'(bd.val)) & kmask;
        rev_new = (((rev_reg & kmask) >> 2) | (CODE_W'(BASE_T - bd.val) << rev_sh)) & kmask;

        vr_inc = {1'b0, vr_reg} + (CW+1)'(1);
        bs_inc = {1'b0, bs_reg} + (CW+1)'(1);
        if (!bd.ok)
            vr_new = '0;
        else if (vr_inc > {1'b0, k_eff})
            vr_new = k_eff;
        else
            vr_new = CW'(vr_inc);
        bs_new = (bs_inc > {1'b0, k_eff}) ? k_eff : CW'(bs_inc);

        phase_inc = {1'b0, phase_reg} + (STRIDE_W+1)'(1);

        hit   = (bs_new == k_eff) && (vr_new == k_eff) && (phase_reg == tgt_reg);
        canon = (fwd_new < rev_new) ? fwd_new : rev_new;
    end

    always_comb
    begin
        dv_psh   = {dv_prem_reg, dv_pnum_reg[STRIDE_W-1]};
        dv_tsh   = {dv_trem_reg, dv_tnum_reg[STRIDE_W-1]};
        dv_pdiff = dv_psh - {1'b0, s_eff};
        dv_tdiff = dv_tsh - {1'b0, s_eff};
        dv_pstep = (dv_psh >= {1'b0, s_eff}) ? dv_pdiff[STRIDE_W-1:0] : dv_psh[STRIDE_W-1:0];
        dv_tstep = (dv_tsh >= {1'b0, s_eff}) ? dv_tdiff[STRIDE_W-1:0] : dv_tsh[STRIDE_W-1:0];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (base_ready)
            s1_valid_next = base_valid;

        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        vr_next    = vr_reg;
        bs_next    = bs_reg;
        phase_next = phase_reg;
        tgt_next   = tgt_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                fwd_next   = '0;
                rev_next   = '0;
                vr_next    = '0;
                bs_next    = '0;
                phase_next = '0;
            end
            else
            begin
                fwd_next   = fwd_new;
                rev_next   = rev_new;
                vr_next    = vr_new;
                bs_next    = bs_new;
                phase_next = (phase_inc >= {1'b0, s_eff}) ? '0 : phase_inc[STRIDE_W-1:0];
            end
        end

        dv_cnt_next  = dv_cnt_reg;
        dv_pnum_next = dv_pnum_reg;
        dv_prem_next = dv_prem_reg;
        dv_tnum_next = dv_tnum_reg;
        dv_trem_next = dv_trem_reg;
        if (cfg_wr)
        begin
            dv_cnt_next = DV_LOAD;
        end
        else if (dv_cnt_reg == DV_LOAD)
        begin
            dv_cnt_next  = dv_cnt_reg - DVC_W'(1);
            dv_pnum_next = phase_reg;
            dv_prem_next = '0;
            dv_tnum_next = STRIDE_W'(k_eff - CW'(1));
            dv_trem_next = '0;
        end
        else if (dv_busy)
        begin
            dv_cnt_next  = dv_cnt_reg - DVC_W'(1);
            dv_pnum_next = {dv_pnum_reg[STRIDE_W-2:0], 1'b0};
            dv_prem_next = dv_pstep;
            dv_tnum_next = {dv_tnum_reg[STRIDE_W-2:0], 1'b0};
            dv_trem_next = dv_tstep;
            if (dv_cnt_reg == DVC_W'(1))
            begin
                phase_next = dv_pstep;
                tgt_next   = dv_tstep;
            end
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && kmer_ready)
            out_valid_next = 1'b0;
        if (s1_fire)
            out_valid_next = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= '0;
            rev_reg       <= '0;
            vr_reg        <= '0;
            bs_reg        <= '0;
            phase_reg     <= '0;
            tgt_reg       <= TGT_RST;
            dv_cnt_reg    <= '0;
            dv_pnum_reg   <= '0;
            dv_prem_reg   <= '0;
            dv_tnum_reg   <= '0;
            dv_trem_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            rev_reg       <= rev_next;
            vr_reg        <= vr_next;
            bs_reg        <= bs_next;
            phase_reg     <= phase_next;
            tgt_reg       <= tgt_next;
            dv_cnt_reg    <= dv_cnt_next;
            dv_pnum_reg   <= dv_pnum_next;
            dv_prem_reg   <= dv_prem_next;
            dv_tnum_reg   <= dv_tnum_next;
            dv_trem_reg   <= dv_trem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (base_valid && base_ready)
        begin
            s1_char_reg <= base_char;
            s1_last_reg <= read_end;
        end
        if (s1_fire && hit)
            out_code_reg <= canon;
    end

    assign last_fire = s1_fire && s1_last_reg;
    assign st_clear  = (fwd_reg == '0) && (rev_reg == '0) && (vr_reg == '0) &&
                       (bs_reg == '0) && (phase_reg == '0);

    `CKMS_ASSERT_ALWAYS(a_run_le_seen, clk, rst_n, vr_reg <= bs_reg, "valid run exceeds bases seen")
    `CKMS_ASSERT_NEXT(a_read_end_clears, clk, rst_n, last_fire, st_clear, "state kept after read end")
    `CKMS_ASSERT_NOW(a_out_from_base, clk, rst_n, $rose(kmer_valid), $past(s1_fire), "k-mer without a base")

endmodule
